### rtl/triac_phase_angle_fan_control_defines.svh
// Assertion macros for the triac phase-angle fan controller.
// Included by the top level; no other dependencies.
`ifndef TRIAC_PHASE_ANGLE_FAN_CONTROL_DEFINES_SVH
`define TRIAC_PHASE_ANGLE_FAN_CONTROL_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define TPAFC_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Condition a implies condition b in the next cycle.
`define TPAFC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

### rtl/tpafc_pkg.sv
// Types, constants and register codes for the triac phase-angle fan controller.
// No dependencies; used by the level queue, the top level and the testbench.
package tpafc_pkg;

	localparam int MvW     = 12;
	localparam int HystW   = 8;
	localparam int TicksW  = 8;
	localparam int LevelW  = 4;
	localparam int DelayW  = 12;

	localparam logic [LevelW-1:0] LevelSteps = 4'd10;
	localparam int QueueDepth = 2;
	localparam int QFillW = $clog2(QueueDepth + 1);
	localparam int QIdxW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	localparam logic [MvW-1:0]    ArmThresholdReset = 12'd500;
	localparam logic [HystW-1:0]  HysteresisReset   = 8'd5;
	localparam logic [TicksW-1:0] TicksPerStepReset = 8'd10;

	localparam int AddrW = 4;
	localparam logic [1:0] RegArmThreshold = 2'd0;
	localparam logic [1:0] RegHysteresis   = 2'd1;
	localparam logic [1:0] RegTicksPerStep = 2'd2;

	localparam logic OpSample = 1'b0;
	localparam logic OpLevel  = 1'b1;

	typedef enum logic [1:0] {
		PhWait  = 2'd0,
		PhDelay = 2'd1,
		PhRise  = 2'd2
	} phase_t;

	typedef struct packed {
		logic              op;
		logic [MvW-1:0]    sample_mv;
		logic [LevelW-1:0] level;
	} item_t;

	typedef struct packed {
		logic              gate;
		logic [1:0]        phase;
		logic [LevelW-1:0] active_level;
		logic              level_dropped;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

### rtl/tpafc_level_queue.sv
// Small FIFO of pending fan-level requests, popped when a half cycle arms.
// Depends on tpafc_pkg.
module tpafc_level_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         pop,
	input  logic [tpafc_pkg::LevelW-1:0] din,
	output logic [tpafc_pkg::LevelW-1:0] head,
	output tpafc_pkg::queue_status_t     status,
	output logic [tpafc_pkg::QFillW-1:0] fill
);

	logic [tpafc_pkg::LevelW-1:0] entry_q [tpafc_pkg::QueueDepth];
	logic [tpafc_pkg::QFillW-1:0] fill_q;

	assign status.full  = (fill_q == tpafc_pkg::QFillW'(tpafc_pkg::QueueDepth));
	assign status.empty = (fill_q == '0);
	assign head = entry_q[0];
	assign fill = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (pop && !status.empty) begin
			fill_q <= fill_q - 1'b1;
		end else if (push && !status.full) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// Entries shift toward the head on a pop; pushes write at the fill point.
	always_ff @(posedge clk) begin
		if (pop && !status.empty) begin
			for (int i = 0; i < tpafc_pkg::QueueDepth - 1; i++) begin
				entry_q[i] <= entry_q[i+1];
			end
		end else if (push && !status.full) begin
			entry_q[fill_q[tpafc_pkg::QIdxW-1:0]] <= din;
		end
	end

endmodule

### rtl/triac_phase_angle_fan_control.sv
// Triac phase-angle fan control: one result out for each request accepted.
// A result is registered in the output buffer when its request is accepted.
// Throughput: one request per cycle; a two-entry output buffer lets input run on
// while a result waits. Stalls only when both output entries are held.
// Reset (arst_n low) idles the phase, turns the gate off, empties the level
// queue and restores the register defaults.
`include "triac_phase_angle_fan_control_defines.svh"

module triac_phase_angle_fan_control (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  tpafc_pkg::item_t            item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tpafc_pkg::result_t          result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpafc_pkg::AddrW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	// Configuration registers.
	logic [tpafc_pkg::MvW-1:0]    thr_q;
	logic [tpafc_pkg::HystW-1:0]  hyst_q;
	logic [tpafc_pkg::TicksW-1:0] ticks_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= tpafc_pkg::ArmThresholdReset;
			hyst_q  <= tpafc_pkg::HysteresisReset;
			ticks_q <= tpafc_pkg::TicksPerStepReset;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tpafc_pkg::RegArmThreshold: thr_q   <= pwdata[tpafc_pkg::MvW-1:0];
				tpafc_pkg::RegHysteresis:   hyst_q  <= pwdata[tpafc_pkg::HystW-1:0];
				tpafc_pkg::RegTicksPerStep: ticks_q <= pwdata[tpafc_pkg::TicksW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tpafc_pkg::RegArmThreshold: prdata = {20'd0, thr_q};
			tpafc_pkg::RegHysteresis:   prdata = {24'd0, hyst_q};
			tpafc_pkg::RegTicksPerStep: prdata = {24'd0, ticks_q};
			default:                    prdata = '0;
		endcase
	end

	// Control state.
	tpafc_pkg::phase_t             phase_q, phase_d;
	logic                          gate_q, gate_d;
	logic [tpafc_pkg::MvW-1:0]     last_q, last_d;
	logic [tpafc_pkg::DelayW-1:0]  delay_q, delay_d;
	logic [tpafc_pkg::LevelW-1:0]  level_q, level_d;

	logic                          accept, is_sample, is_level;
	logic [tpafc_pkg::MvW-1:0]     s;
	logic                          arm;
	logic [tpafc_pkg::LevelW-1:0]  taken, clamped, steps_left;
	logic [tpafc_pkg::DelayW-1:0]  delay_arm;
	logic [tpafc_pkg::MvW-1:0]     diff;
	logic                          q_pop;
	logic [tpafc_pkg::LevelW-1:0]  q_head;
	tpafc_pkg::queue_status_t      q_status;
	logic [tpafc_pkg::QFillW-1:0]  q_fill;
	tpafc_pkg::result_t            res_d;

	assign accept    = item_valid && item_ready;
	assign is_sample = accept && (item.op == tpafc_pkg::OpSample);
	assign is_level  = accept && (item.op == tpafc_pkg::OpLevel);
	assign s         = item.sample_mv;

	assign arm     = (last_q > s) && (s > thr_q);
	assign taken   = q_status.empty ? level_q : q_head;
	assign clamped = (taken > tpafc_pkg::LevelSteps) ? tpafc_pkg::LevelSteps : taken;
	assign steps_left = tpafc_pkg::LevelSteps - clamped;
	assign delay_arm  = {8'd0, steps_left} * {4'd0, ticks_q};
	assign diff = (last_q > s) ? (last_q - s) : (s - last_q);

	tpafc_level_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (is_level),
		.pop    (q_pop),
		.din    (item.level),
		.head   (q_head),
		.status (q_status),
		.fill   (q_fill)
	);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (is_sample) begin
			unique case (phase_q)
				tpafc_pkg::PhWait:  if (arm && clamped != '0) phase_d = tpafc_pkg::PhDelay;
				tpafc_pkg::PhDelay: if (delay_q == '0) phase_d = tpafc_pkg::PhRise;
				tpafc_pkg::PhRise:  if (last_q < s) phase_d = tpafc_pkg::PhWait;
				default:            phase_d = tpafc_pkg::PhWait;
			endcase
		end
	end

	// Gate, delay counter, level and queue pop.
	always_comb begin
		gate_d  = gate_q;
		delay_d = delay_q;
		level_d = level_q;
		q_pop   = 1'b0;
		if (is_sample) begin
			unique case (phase_q)
				tpafc_pkg::PhWait: begin
					if (arm) begin
						q_pop   = !q_status.empty;
						level_d = clamped;
						// Full level keeps the gate as it is; anything lower drops it.
						if (clamped != tpafc_pkg::LevelSteps) gate_d = 1'b0;
						if (clamped != '0) delay_d = delay_arm;
					end
				end
				tpafc_pkg::PhDelay: begin
					if (delay_q == '0) gate_d = 1'b1;
					else delay_d = delay_q - 1'b1;
				end
				tpafc_pkg::PhRise: ;
				default: gate_d = 1'b0;
			endcase
		end
	end

	assign last_d = (is_sample && (diff > {4'd0, hyst_q})) ? s : last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tpafc_pkg::PhWait;
			gate_q  <= 1'b0;
			last_q  <= '0;
			delay_q <= '0;
			level_q <= '0;
		end else begin
			phase_q <= phase_d;
			gate_q  <= gate_d;
			last_q  <= last_d;
			delay_q <= delay_d;
			level_q <= level_d;
		end
	end

	assign res_d.gate          = gate_d;
	assign res_d.phase         = phase_d;
	assign res_d.active_level  = level_d;
	assign res_d.level_dropped = is_level && q_status.full;

	// Two-entry output buffer; entry 0 is the head.
	tpafc_pkg::result_t ob_q [2];
	logic [1:0]         ob_cnt_q;
	logic               ob_pop;

	assign ob_pop       = result_valid && result_ready;
	assign result_valid = (ob_cnt_q != 2'd0);
	assign result       = ob_q[0];
	assign item_ready   = (ob_cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (accept && !ob_pop) begin
			ob_cnt_q <= ob_cnt_q + 2'd1;
		end else if (!accept && ob_pop) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_pop) begin
			ob_q[0] <= (ob_cnt_q == 2'd2) ? ob_q[1] : res_d;
			if (accept) ob_q[1] <= res_d;
		end else if (accept) begin
			if (ob_cnt_q == 2'd0) ob_q[0] <= res_d;
			else ob_q[1] <= res_d;
		end
	end

	`TPAFC_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1,
		q_fill <= tpafc_pkg::QFillW'(tpafc_pkg::QueueDepth))
	`TPAFC_ASSERT_NEXT(a_delay_done, clk, arst_n,
		is_sample && phase_q == tpafc_pkg::PhDelay && delay_q == '0,
		gate_q && phase_q == tpafc_pkg::PhRise)
	`TPAFC_ASSERT_NOW(a_level_range, clk, arst_n, result_valid,
		result.active_level <= tpafc_pkg::LevelSteps)

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triac phase-angle fan controller.
// Depends on tpafc_pkg and triac_phase_angle_fan_control; predicts every result in place.
module tb;
	import tpafc_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 300;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_ready;
	item_t             item         = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	result_t           result;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [AddrW-1:0]  paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;

	triac_phase_angle_fan_control DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the controller's registers and state.
	logic [MvW-1:0]    cfg_arm_mv  = ArmThresholdReset;
	logic [HystW-1:0]  cfg_hyst_mv = HysteresisReset;
	logic [TicksW-1:0] cfg_ticks   = TicksPerStepReset;
	phase_t            fan_phase   = PhWait;
	logic [MvW-1:0]    prev_mv     = '0;
	logic [DelayW-1:0] delay_left  = '0;
	logic [LevelW-1:0] level_now   = '0;
	logic [LevelW-1:0] level_fifo[$];
	logic              gate_now    = 1'b0;

	result_t pending_fan_results[$];
	int      fail_count = 0;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_ask   = 0;

	int wave_mv       = 0;
	int wave_peak     = 3000;
	int wave_floor    = 0;
	int wave_step_max = 150;
	bit wave_rising   = 1'b1;

	function automatic result_t advance_fan_state(input item_t it);
		result_t           res;
		logic [MvW-1:0]    s;
		logic [MvW-1:0]    change;
		int                delay_full;
		res = '0;
		s = it.sample_mv;
		if (it.op == OpLevel) begin
			if (level_fifo.size() < QueueDepth)
				level_fifo.push_back(it.level);
			else
				res.level_dropped = 1'b1;
		end else begin
			case (fan_phase)
				PhWait: begin
					if (prev_mv > s && s > cfg_arm_mv) begin
						if (level_fifo.size() > 0)
							level_now = level_fifo.pop_front();
						if (level_now > LevelSteps)
							level_now = LevelSteps;
						if (level_now == '0) begin
							gate_now = 1'b0;
						end else begin
							// At full level the gate is left as it was.
							if (level_now < LevelSteps)
								gate_now = 1'b0;
							delay_full = (int'(LevelSteps) - int'(level_now)) * int'(cfg_ticks);
							delay_left = DelayW'(delay_full);
							fan_phase = PhDelay;
						end
					end
				end
				PhDelay: begin
					if (delay_left == '0) begin
						gate_now = 1'b1;
						fan_phase = PhRise;
					end else begin
						delay_left = delay_left - 1'b1;
					end
				end
				PhRise: begin
					if (prev_mv < s)
						fan_phase = PhWait;
				end
				default: begin
					gate_now = 1'b0;
					fan_phase = PhWait;
				end
			endcase
			change = (prev_mv > s) ? prev_mv - s : s - prev_mv;
			if (change > cfg_hyst_mv)
				prev_mv = s;
		end
		res.gate = gate_now;
		res.phase = fan_phase;
		res.active_level = level_now;
		return res;
	endfunction

	function automatic int stall_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic item_t level_item(input logic [LevelW-1:0] lv);
		item_t it;
		it = '0;
		it.op = OpLevel;
		it.level = lv;
		return it;
	endfunction

	function automatic item_t sample_item(input logic [MvW-1:0] mv);
		item_t it;
		it = '0;
		it.op = OpSample;
		it.sample_mv = mv;
		return it;
	endfunction

	// Triangle-shaped mains waveform with random slopes and peaks.
	function automatic logic [MvW-1:0] next_wave_mv();
		int step;
		step = $urandom_range(1, wave_step_max);
		if (wave_rising) begin
			wave_mv += step;
			if (wave_mv >= wave_peak) begin
				wave_mv = wave_peak;
				wave_rising = 1'b0;
				wave_floor = $urandom_range(0, 400);
			end
		end else begin
			wave_mv -= step;
			if (wave_mv <= wave_floor) begin
				wave_mv = wave_floor;
				wave_rising = 1'b1;
				wave_peak = $urandom_range(600, 4095);
			end
		end
		return MvW'(wave_mv);
	endfunction

	function automatic item_t random_fan_item();
		item_t it;
		int    r;
		r = $urandom_range(0, 99);
		it.op = OpSample;
		it.sample_mv = MvW'($urandom);
		it.level = LevelW'($urandom);
		if (r < 12) begin
			it.op = OpLevel;
			if (r < 7)
				it.level = LevelW'($urandom_range(1, 10));
		end else if (r >= 17) begin
			it.sample_mv = next_wave_mv();
		end
		return it;
	endfunction

	task automatic send_fan_item(input item_t it);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 99) >= 60) ? stall_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		pending_fan_results.push_back(advance_fan_state(it));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_fan_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_reg(input logic [1:0] idx, output logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		read_reg(idx, readback);
		if (readback !== value) begin
			$error("register %0d: expected %h, got %h", idx, value, readback);
			fail_count++;
		end
	endtask

	task automatic set_config(input logic [MvW-1:0] arm, input logic [HystW-1:0] hyst,
			input logic [TicksW-1:0] ticks);
		wait_drained();
		program_reg(RegArmThreshold, 32'(arm));
		cfg_arm_mv = arm;
		program_reg(RegHysteresis, 32'(hyst));
		cfg_hyst_mv = hyst;
		program_reg(RegTicksPerStep, 32'(ticks));
		cfg_ticks = ticks;
	endtask

	task automatic run_wave_phase(input int count);
		repeat (count) send_fan_item(random_fan_item());
	endtask

	task automatic test_register_defaults();
		logic [31:0] value;
		read_reg(RegArmThreshold, value);
		if (value !== 32'(ArmThresholdReset)) begin
			$error("arm_threshold_mv: expected %0d, got %0d", ArmThresholdReset, value);
			fail_count++;
		end
		read_reg(RegHysteresis, value);
		if (value !== 32'(HysteresisReset)) begin
			$error("change_hysteresis_mv: expected %0d, got %0d", HysteresisReset, value);
			fail_count++;
		end
		read_reg(RegTicksPerStep, value);
		if (value !== 32'(TicksPerStepReset)) begin
			$error("ticks_per_step: expected %0d, got %0d", TicksPerStepReset, value);
			fail_count++;
		end
	endtask

	task automatic test_directed_cases();
		set_config(12'd500, 8'd5, 8'd1);
		// An over-range level, then a zero level; the third request finds the queue full.
		send_fan_item(level_item(4'd15));
		send_fan_item(level_item(4'd0));
		send_fan_item(level_item(4'd10));
		send_fan_item(sample_item(12'd4095));
		// Arms with the clamped full level, so the gate fires on the next sample.
		send_fan_item(sample_item(12'd3000));
		send_fan_item(sample_item(12'd2000));
		send_fan_item(sample_item(12'd2500));
		// Arms with level zero, which forces the gate low and stays idle.
		send_fan_item(sample_item(12'd1000));
		send_fan_item(level_item(4'd3));
		send_fan_item(sample_item(12'd4095));
		// A fall within the hysteresis still arms against the remembered peak.
		send_fan_item(sample_item(12'd4094));
		send_fan_item(sample_item(12'd0));
		send_fan_item(sample_item(12'd4095));
		send_fan_item(sample_item(12'd0));
		send_fan_item(sample_item(12'd4095));
		send_fan_item(sample_item(12'd2000));
		send_fan_item(sample_item(12'd1500));
		send_fan_item(sample_item(12'd1000));
		send_fan_item(sample_item(12'd800));
		send_fan_item(sample_item(12'd900));
		// Falling onto the threshold itself must not arm.
		send_fan_item(sample_item(12'd500));
		send_fan_item(sample_item(12'd3000));
	endtask

	task automatic test_wave_sweeps();
		set_config(ArmThresholdReset, HysteresisReset, TicksPerStepReset);
		wave_step_max = 150;
		run_wave_phase(200);
		set_config(12'd0, 8'd0, 8'd1);
		run_wave_phase(150);
		set_config(12'd4095, 8'd255, 8'd255);
		run_wave_phase(60);
		set_config(12'd1500, 8'd255, 8'd3);
		wave_step_max = 300;
		run_wave_phase(120);
		set_config(12'd300, 8'd0, 8'd255);
		wave_step_max = 150;
		run_wave_phase(100);
		// A zero ticks-per-step setting gives no delay at all.
		set_config(12'd800, 8'd20, 8'd0);
		run_wave_phase(100);
	endtask

	task automatic test_output_backpressure();
		set_config(12'd700, 8'd10, 8'd2);
		tx_idle_on = 1'b0;
		send_fan_item(random_fan_item());
		// The receiver stops taking results while requests keep coming.
		hold_ask++;
		run_wave_phase(40);
		wait_drained();
		run_wave_phase(20);
		tx_idle_on = 1'b1;
	endtask

	task automatic test_quiet_stretch();
		set_config(MvW'($urandom_range(0, 2000)), HystW'($urandom_range(0, 255)),
			TicksW'($urandom_range(1, 4)));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_wave_phase(100);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	int rx_stall_left = 0;
	int hold_seen     = 0;

	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			rx_stall_left = HoldCycles;
		end else if (rx_stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 25) begin
			rx_stall_left = stall_length();
		end
		if (rx_stall_left > 0) begin
			result_ready <= 1'b0;
			rx_stall_left--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_fan_results.size() == 0) begin
				$error("result %h arrived with no request outstanding", result);
				fail_count++;
			end else begin
				want = pending_fan_results.pop_front();
				if (result.gate !== want.gate) begin
					$error("gate: expected %0d, got %0d", want.gate, result.gate);
					fail_count++;
				end
				if (result.phase !== want.phase) begin
					$error("phase: expected %0d, got %0d", want.phase, result.phase);
					fail_count++;
				end
				if (result.active_level !== want.active_level) begin
					$error("active_level: expected %0d, got %0d", want.active_level,
						result.active_level);
					fail_count++;
				end
				if (result.level_dropped !== want.level_dropped) begin
					$error("level_dropped: expected %0d, got %0d", want.level_dropped,
						result.level_dropped);
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_register_defaults();
		test_directed_cases();
		test_wave_sweeps();
		test_output_backpressure();
		test_quiet_stretch();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### triac_phase_angle_fan_control.f
+incdir+rtl
rtl/tpafc_pkg.sv
rtl/tpafc_level_queue.sv
rtl/triac_phase_angle_fan_control.sv
test/tb.sv
